FILE: rtl/mphp_pkg.sv
// ----------------------------------------------------------------------------
// mphp_pkg
// Shared types, codes and helpers of the packet header parser: phase codes,
// command codes, the per-packet snapshot and the result record.
// ----------------------------------------------------------------------------
`default_nettype none

package mphp_pkg;

  localparam int LEN_W = 28;  // remaining length and sizes
  localparam int OFS_W = 29;  // offsets from packet start
  localparam int POS_W = 30;  // body position with headroom for overflow checks
  localparam int CUR_W = 18;  // cursor into the publish variable header

  // command codes
  localparam logic [3:0] CMD_CONNACK   = 4'd2;
  localparam logic [3:0] CMD_PUBLISH   = 4'd3;
  localparam logic [3:0] CMD_ACK_FIRST = 4'd4;
  localparam logic [3:0] CMD_ACK_LAST  = 4'd11;

  // byte-level parse phase
  typedef enum logic [6:0] {
    PH_HDR       = 7'b0000001,
    PH_LEN       = 7'b0000010,
    PH_BODY      = 7'b0000100,
    PH_PUB_TOPIC = 7'b0001000,
    PH_PUB_ID    = 7'b0010000,
    PH_PUB_PROP  = 7'b0100000,
    PH_PUB_TAIL  = 7'b1000000
  } phase_t;

  // state of one packet as seen on its last byte
  typedef struct packed {
    logic             overlong;
    logic [3:0]       cmd;
    logic [1:0]       qos;
    logic [LEN_W-1:0] n;
    logic [2:0]       len_cnt;
    logic [15:0]      topic_len;
    logic [15:0]      id;
    logic [7:0]       ack;
    logic [LEN_W-1:0] prop_size;
    logic [2:0]       prop_cnt;
    logic             prop_done;
    logic             v5;
  } snap_t;

  // partly checked packet, between the two check stages
  typedef struct packed {
    logic             bad;
    logic [3:0]       cmd;
    logic [1:0]       qos;
    logic [LEN_W-1:0] n;
    logic [2:0]       hdr;
    logic [15:0]      pid;
    logic [7:0]       ack;
    logic [15:0]      tl;
    logic             is_pub;
    logic             use_props;
    logic [CUR_W-1:0] p_id;
    logic [2:0]       prop_cnt;
    logic [LEN_W-1:0] prop_size;
    logic [POS_W-1:0] p_end;
  } mid_t;

  // one result transaction
  typedef struct packed {
    logic             status;
    logic [3:0]       command;
    logic [1:0]       qos_level;
    logic [OFS_W-1:0] packet_length;
    logic [LEN_W-1:0] remaining_length;
    logic [15:0]      packet_id;
    logic [7:0]       ack_code;
    logic [15:0]      topic_length;
    logic [OFS_W-1:0] prop_offset;
    logic [LEN_W-1:0] prop_length;
    logic [OFS_W-1:0] payload_offset;
    logic [LEN_W-1:0] payload_length;
  } res_t;

  // merge seven varint bits into an accumulator at group idx
  function automatic logic [LEN_W-1:0] varint_add(input logic [LEN_W-1:0] acc,
                                                  input logic [7:0]       b,
                                                  input logic [1:0]       idx);
    logic [LEN_W-1:0] part;
    part = '0;
    case (idx)
      2'd0:    part = {21'd0, b[6:0]};
      2'd1:    part = {14'd0, b[6:0], 7'd0};
      2'd2:    part = {7'd0, b[6:0], 14'd0};
      2'd3:    part = {b[6:0], 21'd0};
      default: part = '0;
    endcase
    return acc | part;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/mphp_parser.sv
// ----------------------------------------------------------------------------
// mphp_parser
// Byte-level state machine: decodes fixed header, remaining length and the
// variable header fields, and presents a packet snapshot on its last byte.
// ----------------------------------------------------------------------------
`default_nettype none

module mphp_parser import mphp_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       byte_en,
  input  wire logic [7:0] rx_byte,
  input  wire logic       v5,
  output logic            snap_valid,
  output snap_t           snap
);

  phase_t           phase_r, phase_nxt, ph_mid;
  logic [3:0]       cmd_r, cmd_nxt;
  logic [1:0]       qos_r, qos_nxt;
  logic [LEN_W-1:0] len_acc_r, len_acc_nxt;
  logic [2:0]       len_cnt_r, len_cnt_nxt;
  logic [LEN_W-1:0] body_cnt_r, body_cnt_nxt;
  logic [CUR_W-1:0] cursor_r, cursor_nxt;
  logic [15:0]      topic_r, topic_nxt;
  logic [15:0]      id_r, id_nxt;
  logic [7:0]       ack_r, ack_nxt;
  logic [LEN_W-1:0] prop_acc_r, prop_acc_nxt;
  logic [2:0]       prop_cnt_r, prop_cnt_nxt;
  logic             fire, overlong, body_step, ack_cmd;

  assign ack_cmd = (cmd_r >= CMD_ACK_FIRST) && (cmd_r <= CMD_ACK_LAST);

  // next state for one accepted byte
  always_comb begin
    phase_nxt    = phase_r;
    ph_mid       = phase_r;
    cmd_nxt      = cmd_r;
    qos_nxt      = qos_r;
    len_acc_nxt  = len_acc_r;
    len_cnt_nxt  = len_cnt_r;
    body_cnt_nxt = body_cnt_r;
    cursor_nxt   = cursor_r;
    topic_nxt    = topic_r;
    id_nxt       = id_r;
    ack_nxt      = ack_r;
    prop_acc_nxt = prop_acc_r;
    prop_cnt_nxt = prop_cnt_r;
    fire         = 1'b0;
    overlong     = 1'b0;
    body_step    = 1'b0;
    if (byte_en) begin
      case (phase_r)
        PH_HDR: begin
          cmd_nxt      = rx_byte[7:4];
          qos_nxt      = rx_byte[2:1];
          len_acc_nxt  = '0;
          len_cnt_nxt  = '0;
          body_cnt_nxt = '0;
          cursor_nxt   = '0;
          topic_nxt    = '0;
          id_nxt       = '0;
          ack_nxt      = '0;
          prop_acc_nxt = '0;
          prop_cnt_nxt = '0;
          phase_nxt    = PH_LEN;
        end
        PH_LEN: begin
          len_acc_nxt = varint_add(len_acc_r, rx_byte, len_cnt_r[1:0]);
          len_cnt_nxt = len_cnt_r + 3'd1;
          if (!rx_byte[7]) begin
            if (len_acc_nxt == '0) begin
              fire      = 1'b1;
              phase_nxt = PH_HDR;
            end else begin
              phase_nxt = (cmd_r == CMD_PUBLISH) ? PH_PUB_TOPIC : PH_BODY;
            end
          end else if (len_cnt_r == 3'd3) begin
            fire      = 1'b1;
            overlong  = 1'b1;
            phase_nxt = PH_HDR;
          end
        end
        PH_BODY: begin
          body_step = 1'b1;
          if (cmd_r == CMD_CONNACK && body_cnt_r == 28'd1) begin
            ack_nxt = rx_byte;
          end
          if (ack_cmd) begin
            if (body_cnt_r == '0) begin
              id_nxt = {rx_byte, 8'd0};
            end else if (body_cnt_r == 28'd1) begin
              id_nxt = {id_r[15:8], rx_byte};
            end
          end
        end
        PH_PUB_TOPIC: begin
          body_step = 1'b1;
          if (body_cnt_r == '0) begin
            topic_nxt = {rx_byte, 8'd0};
          end else if (body_cnt_r == 28'd1) begin
            topic_nxt  = {topic_r[15:8], rx_byte};
            cursor_nxt = CUR_W'(2) + {2'b00, topic_nxt};
            ph_mid     = (qos_r != 2'd0) ? PH_PUB_ID : PH_PUB_PROP;
          end
        end
        PH_PUB_ID: begin
          body_step = 1'b1;
          if (body_cnt_r == {10'd0, cursor_r}) begin
            id_nxt = {rx_byte, 8'd0};
          end else if (body_cnt_r == {10'd0, cursor_r + CUR_W'(1)}) begin
            id_nxt     = {id_r[15:8], rx_byte};
            cursor_nxt = cursor_r + CUR_W'(2);
            ph_mid     = PH_PUB_PROP;
          end
        end
        PH_PUB_PROP: begin
          body_step = 1'b1;
          if (body_cnt_r >= {10'd0, cursor_r} && !prop_cnt_r[2]) begin
            prop_acc_nxt = varint_add(prop_acc_r, rx_byte, prop_cnt_r[1:0]);
            prop_cnt_nxt = prop_cnt_r + 3'd1;
            if (!rx_byte[7]) begin
              ph_mid = PH_PUB_TAIL;
            end
          end
        end
        PH_PUB_TAIL: begin
          body_step = 1'b1;
        end
        default: begin
          phase_nxt = PH_HDR;
        end
      endcase
      // body position and end of packet
      if (body_step) begin
        body_cnt_nxt = body_cnt_r + 28'd1;
        if (body_cnt_nxt >= len_acc_r) begin
          fire      = 1'b1;
          phase_nxt = PH_HDR;
        end else begin
          phase_nxt = ph_mid;
        end
      end
    end
  end

  // snapshot of the packet on its last byte
  always_comb begin
    snap_valid     = fire;
    snap.overlong  = overlong;
    snap.cmd       = cmd_r;
    snap.qos       = qos_r;
    snap.n         = len_acc_nxt;
    snap.len_cnt   = len_cnt_nxt;
    snap.topic_len = topic_nxt;
    snap.id        = id_nxt;
    snap.ack       = ack_nxt;
    snap.prop_size = prop_acc_nxt;
    snap.prop_cnt  = prop_cnt_nxt;
    snap.prop_done = (ph_mid == PH_PUB_TAIL);
    snap.v5        = v5;
  end

  // phase register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HDR;
    end else begin
      phase_r <= phase_nxt;
    end
  end

  // field registers, cleared on every header byte
  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    qos_r      <= qos_nxt;
    len_acc_r  <= len_acc_nxt;
    len_cnt_r  <= len_cnt_nxt;
    body_cnt_r <= body_cnt_nxt;
    cursor_r   <= cursor_nxt;
    topic_r    <= topic_nxt;
    id_r       <= id_nxt;
    ack_r      <= ack_nxt;
    prop_acc_r <= prop_acc_nxt;
    prop_cnt_r <= prop_cnt_nxt;
  end

endmodule

`default_nettype wire

FILE: rtl/mphp_calc.sv
// ----------------------------------------------------------------------------
// mphp_calc
// Two-stage length check and offset computation on packet snapshots, with
// the result register and the discard of everything after a malformed packet.
// ----------------------------------------------------------------------------
`default_nettype none

module mphp_calc import mphp_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  snap_valid,
  input  wire snap_t snap,
  output logic       snap_ready,
  output logic       res_valid,
  input  wire logic  res_ready,
  output res_t       res
);

  logic  s1_v_r, s2_v_r, out_v_r, drop_r;
  logic  s1_v_nxt, s2_v_nxt, out_v_nxt, drop_nxt;
  snap_t s1_r;
  mid_t  s2_r, mid;
  res_t  out_r, fin;
  logic  rdy_out, rdy_s2, rdy_s1, s2_move, out_load;

  // stage 1: header checks and end of variable header
  logic             is_ca, is_ack, is_pub, short_n, use_props;
  logic [CUR_W-1:0] p_tl, p_id;

  always_comb begin
    is_ca     = (s1_r.cmd == CMD_CONNACK);
    is_ack    = (s1_r.cmd >= CMD_ACK_FIRST) && (s1_r.cmd <= CMD_ACK_LAST);
    is_pub    = (s1_r.cmd == CMD_PUBLISH);
    short_n   = (s1_r.n < 28'd2);
    p_tl      = CUR_W'(2) + {2'b00, s1_r.topic_len};
    p_id      = p_tl + ((s1_r.qos != 2'd0) ? CUR_W'(2) : CUR_W'(0));
    use_props = is_pub && s1_r.v5 && (({10'd0, p_id} + 28'd2) < s1_r.n);

    mid.bad = s1_r.overlong
           || ((is_ca || is_ack || is_pub) && short_n)
           || (is_pub && ({10'd0, p_tl} > s1_r.n))
           || (is_pub && (s1_r.qos != 2'd0) && ({10'd0, p_id} > s1_r.n))
           || (use_props && !s1_r.prop_done);
    mid.cmd       = s1_r.cmd;
    mid.qos       = s1_r.qos;
    mid.n         = s1_r.n;
    mid.hdr       = 3'd1 + s1_r.len_cnt;
    mid.pid       = (is_ack || (is_pub && s1_r.qos != 2'd0)) ? s1_r.id : 16'd0;
    mid.ack       = is_ca ? s1_r.ack : 8'd0;
    mid.tl        = is_pub ? s1_r.topic_len : 16'd0;
    mid.is_pub    = is_pub;
    mid.use_props = use_props;
    mid.p_id      = p_id;
    mid.prop_cnt  = s1_r.prop_cnt;
    mid.prop_size = s1_r.prop_size;
    mid.p_end     = use_props ? (POS_W'(p_id) + POS_W'(s1_r.prop_cnt)
                                 + POS_W'(s1_r.prop_size))
                              : POS_W'(p_id);
  end

  // stage 2: final fit check and offsets
  logic bad2;

  always_comb begin
    bad2 = s2_r.bad || (s2_r.is_pub && (s2_r.p_end > POS_W'(s2_r.n)));
    fin  = '0;
    fin.status    = bad2;
    fin.command   = s2_r.cmd;
    fin.qos_level = s2_r.qos;
    if (!bad2) begin
      fin.packet_length    = OFS_W'(s2_r.hdr) + OFS_W'(s2_r.n);
      fin.remaining_length = s2_r.n;
      fin.packet_id        = s2_r.pid;
      fin.ack_code         = s2_r.ack;
      fin.topic_length     = s2_r.tl;
      if (s2_r.use_props) begin
        fin.prop_offset = OFS_W'(s2_r.hdr) + OFS_W'(s2_r.p_id) + OFS_W'(s2_r.prop_cnt);
        fin.prop_length = s2_r.prop_size;
      end
      if (s2_r.is_pub) begin
        fin.payload_offset = OFS_W'(s2_r.hdr) + s2_r.p_end[OFS_W-1:0];
        fin.payload_length = s2_r.n - s2_r.p_end[LEN_W-1:0];
      end
    end
  end

  // flow control: stages collapse bubbles, dropped results need no room
  always_comb begin
    rdy_out    = !out_v_r || res_ready;
    s2_move    = s2_v_r && (rdy_out || drop_r);
    rdy_s2     = !s2_v_r || rdy_out || drop_r;
    rdy_s1     = !s1_v_r || rdy_s2;
    snap_ready = rdy_s1;
    out_load   = s2_move && !drop_r;

    s1_v_nxt  = s1_v_r;
    s2_v_nxt  = s2_v_r;
    out_v_nxt = out_v_r;
    drop_nxt  = drop_r || (out_load && bad2);
    if (out_v_r && res_ready) begin
      out_v_nxt = 1'b0;
    end
    if (out_load) begin
      out_v_nxt = 1'b1;
    end
    if (s2_move) begin
      s2_v_nxt = 1'b0;
    end
    if (s1_v_r && rdy_s2) begin
      s2_v_nxt = 1'b1;
      s1_v_nxt = 1'b0;
    end
    if (snap_valid && rdy_s1) begin
      s1_v_nxt = 1'b1;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      out_v_r <= 1'b0;
      drop_r  <= 1'b0;
    end else begin
      s1_v_r  <= s1_v_nxt;
      s2_v_r  <= s2_v_nxt;
      out_v_r <= out_v_nxt;
      drop_r  <= drop_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (snap_valid && rdy_s1) begin
      s1_r <= snap;
    end
    if (s1_v_r && rdy_s2) begin
      s2_r <= mid;
    end
    if (out_load) begin
      out_r <= fin;
    end
  end

  assign res_valid = out_v_r;
  assign res       = out_r;

endmodule

`default_nettype wire

FILE: rtl/mqtt_packet_header_parser_core.sv
// ----------------------------------------------------------------------------
// mqtt_packet_header_parser_core
// Control packet header parser for a back-to-back byte stream.
// ----------------------------------------------------------------------------
// Usage:
//   in_* is a valid/ready byte channel carrying whole control packets back
//   to back. One byte is taken per clock cycle while in_ready is high. Each
//   packet up to and including the first malformed one gives exactly one
//   transaction on the out_* channel, produced by its last byte (or by the
//   fourth length byte if it still has its continuation bit set). A result
//   passes from its last byte through the snapshot register, one check stage
//   and one offset stage into the result register. The byte state machine
//   touches every byte once, one byte per cycle while in_ready is high.
//   While a result waits on out_ready, the two check stages keep absorbing
//   packets; in_ready drops only when all three result slots are full.
//   After a malformed result every further packet is dropped without a
//   result until reset.
//   cfg_we/cfg_wdata write the version 5 mode bit; write it only while idle.
//   Reset (rst_n low, synchronous) returns to waiting for a header byte,
//   empties the result path and clears the version 5 mode bit.
// ----------------------------------------------------------------------------
`default_nettype none

module mqtt_packet_header_parser_core import mphp_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             cfg_we,
  input  wire logic             cfg_wdata,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic [7:0]       in_rx_byte,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic                  out_status,
  output logic [3:0]            out_command,
  output logic [1:0]            out_qos_level,
  output logic [OFS_W-1:0]      out_packet_length,
  output logic [LEN_W-1:0]      out_remaining_length,
  output logic [15:0]           out_packet_id,
  output logic [7:0]            out_ack_code,
  output logic [15:0]           out_topic_length,
  output logic [OFS_W-1:0]      out_prop_offset,
  output logic [LEN_W-1:0]      out_prop_length,
  output logic [OFS_W-1:0]      out_payload_offset,
  output logic [LEN_W-1:0]      out_payload_length
);

  logic  v5_r;
  logic  byte_en, snap_valid, snap_ready;
  snap_t snap;
  res_t  res;

  // version 5 mode register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v5_r <= 1'b0;
    end else if (cfg_we) begin
      v5_r <= cfg_wdata;
    end
  end

  // input handshake
  assign in_ready = snap_ready;
  assign byte_en  = in_valid && snap_ready;

  mphp_parser u_parser (
    .clk        (clk),
    .rst_n      (rst_n),
    .byte_en    (byte_en),
    .rx_byte    (in_rx_byte),
    .v5         (v5_r),
    .snap_valid (snap_valid),
    .snap       (snap)
  );

  mphp_calc u_calc (
    .clk        (clk),
    .rst_n      (rst_n),
    .snap_valid (snap_valid),
    .snap       (snap),
    .snap_ready (snap_ready),
    .res_valid  (out_valid),
    .res_ready  (out_ready),
    .res        (res)
  );

  // result fields
  assign out_status           = res.status;
  assign out_command          = res.command;
  assign out_qos_level        = res.qos_level;
  assign out_packet_length    = res.packet_length;
  assign out_remaining_length = res.remaining_length;
  assign out_packet_id        = res.packet_id;
  assign out_ack_code         = res.ack_code;
  assign out_topic_length     = res.topic_length;
  assign out_prop_offset      = res.prop_offset;
  assign out_prop_length      = res.prop_length;
  assign out_payload_offset   = res.payload_offset;
  assign out_payload_length   = res.payload_length;

endmodule

`default_nettype wire

FILE: dv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Stream-level check of the control packet header parser. Whole packets are
// queued as bytes and fed through a valid/ready driver with random gaps. Each
// accepted byte runs through a byte-accurate parse model kept in this module,
// and every result transaction is compared field by field against it. The run
// walks through both protocol modes and ends on one malformed packet, drawn
// at random, followed by bytes that must be dropped.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import mphp_pkg::*;

  // command codes without a name in the package
  localparam logic [3:0] CMD_RESERVED   = 4'd0;
  localparam logic [3:0] CMD_CONNECT    = 4'd1;
  localparam logic [3:0] CMD_PUBACK     = 4'd4;
  localparam logic [3:0] CMD_SUBSCRIBE  = 4'd8;
  localparam logic [3:0] CMD_PINGREQ    = 4'd12;
  localparam logic [3:0] CMD_PINGRESP   = 4'd13;
  localparam logic [3:0] CMD_DISCONNECT = 4'd14;
  localparam logic [3:0] CMD_AUTH       = 4'd15;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             cfg_we = 1'b0;
  logic             cfg_wdata = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_ready;
  logic [7:0]       in_rx_byte = 8'h00;
  logic             out_valid;
  logic             out_ready = 1'b0;
  logic             out_status;
  logic [3:0]       out_command;
  logic [1:0]       out_qos_level;
  logic [OFS_W-1:0] out_packet_length;
  logic [LEN_W-1:0] out_remaining_length;
  logic [15:0]      out_packet_id;
  logic [7:0]       out_ack_code;
  logic [15:0]      out_topic_length;
  logic [OFS_W-1:0] out_prop_offset;
  logic [LEN_W-1:0] out_prop_length;
  logic [OFS_W-1:0] out_payload_offset;
  logic [LEN_W-1:0] out_payload_length;

  mqtt_packet_header_parser_core DUT (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_we               (cfg_we),
    .cfg_wdata            (cfg_wdata),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_rx_byte           (in_rx_byte),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_status           (out_status),
    .out_command          (out_command),
    .out_qos_level        (out_qos_level),
    .out_packet_length    (out_packet_length),
    .out_remaining_length (out_remaining_length),
    .out_packet_id        (out_packet_id),
    .out_ack_code         (out_ack_code),
    .out_topic_length     (out_topic_length),
    .out_prop_offset      (out_prop_offset),
    .out_prop_length      (out_prop_length),
    .out_payload_offset   (out_payload_offset),
    .out_payload_length   (out_payload_length)
  );

  always #2 clk = ~clk;

  // byte stream and expected headers
  logic [7:0] tx_bytes[$];
  logic [7:0] pkt_body[$];
  res_t       expected_headers[$];
  int         tx_count = 0;
  int         headers_seen = 0;
  int         errors = 0;

  // handshake bookkeeping, sampled at the rising edge
  bit in_taken = 1'b0;
  bit out_taken = 1'b0;
  int feed_gap = 0;
  bit feed_calm = 1'b0;
  int drain_wait = 0;
  bit drain_calm = 1'b0;
  int hold_left = 0;
  bit hold_done = 1'b0;

  // parse model state
  bit               mode_v5 = 1'b0;
  phase_t           parse_phase = PH_HDR;
  logic [3:0]       hdr_cmd = '0;
  logic [1:0]       hdr_qos = '0;
  int unsigned      rem_len = 0;
  int unsigned      len_bytes = 0;
  int unsigned      body_pos = 0;
  int unsigned      field_pos = 0;
  int unsigned      topic_len = 0;
  int unsigned      pkt_id = 0;
  int unsigned      ack_byte = 0;
  int unsigned      prop_len = 0;
  int unsigned      prop_bytes = 0;
  bit               stuck = 1'b0;

  // header of the packet that just ended, malformed if overlong, too short or with an unfinished property length
  function automatic res_t close_packet(input bit overlong);
    longint unsigned n, hdr, p, pid, ack, tl, pst, psz, poff, plen;
    bit bad;
    res_t r;
    n = 64'(rem_len);
    hdr = 64'(len_bytes) + 1;
    p = 0; pid = 0; ack = 0; tl = 0; pst = 0; psz = 0; poff = 0; plen = 0;
    bad = overlong;
    if (overlong) begin
    end else if (hdr_cmd == CMD_CONNACK) begin
      if (n < 2) bad = 1'b1; else ack = 64'(ack_byte);
    end else if (hdr_cmd >= CMD_ACK_FIRST && hdr_cmd <= CMD_ACK_LAST) begin
      if (n < 2) bad = 1'b1; else pid = 64'(pkt_id);
    end else if (hdr_cmd == CMD_PUBLISH) begin
      if (n < 2) begin
        bad = 1'b1;
      end else begin
        tl = 64'(topic_len);
        p = 2 + tl;
        if (p > n) bad = 1'b1;
        if (!bad && hdr_qos != 0) begin
          if (p + 2 > n) bad = 1'b1;
          else begin
            pid = 64'(pkt_id);
            p += 2;
          end
        end
        // properties only when more than two bytes follow topic and id
        if (!bad && mode_v5 && p + 2 < n) begin
          if (parse_phase != PH_PUB_TAIL) bad = 1'b1;
          else begin
            psz = 64'(prop_len);
            pst = hdr + p + 64'(prop_bytes);
            p += 64'(prop_bytes) + psz;
          end
        end
        if (!bad && p > n) bad = 1'b1;
        if (!bad) begin
          poff = hdr + p;
          plen = n - p;
        end
      end
    end
    r = '0;
    r.command = hdr_cmd;
    r.qos_level = hdr_qos;
    if (bad) begin
      r.status = 1'b1;
      stuck = 1'b1;
    end else begin
      r.packet_length = OFS_W'(hdr + n);
      r.remaining_length = LEN_W'(n);
      r.packet_id = 16'(pid);
      r.ack_code = 8'(ack);
      r.topic_length = 16'(tl);
      r.prop_offset = OFS_W'(pst);
      r.prop_length = LEN_W'(psz);
      r.payload_offset = OFS_W'(poff);
      r.payload_length = LEN_W'(plen);
    end
    parse_phase = PH_HDR;
    return r;
  endfunction

  // advance the parse model by one byte, returns 1 when a header is complete
  function automatic bit parse_byte(input logic [7:0] b, output res_t r);
    int unsigned i;
    r = '0;
    if (stuck) return 1'b0;
    if (parse_phase == PH_HDR) begin
      hdr_cmd = b[7:4];
      hdr_qos = b[2:1];
      rem_len = 0; len_bytes = 0; body_pos = 0; field_pos = 0;
      topic_len = 0; pkt_id = 0; ack_byte = 0; prop_len = 0; prop_bytes = 0;
      parse_phase = PH_LEN;
      return 1'b0;
    end
    if (parse_phase == PH_LEN) begin
      rem_len = rem_len | (32'(b[6:0]) << (7 * (len_bytes & 3)));
      len_bytes++;
      if (!b[7]) begin
        if (rem_len == 0) begin
          r = close_packet(1'b0);
          return 1'b1;
        end
        parse_phase = (hdr_cmd == CMD_PUBLISH) ? PH_PUB_TOPIC : PH_BODY;
        return 1'b0;
      end
      if (len_bytes >= 4) begin
        r = close_packet(1'b1);
        return 1'b1;
      end
      return 1'b0;
    end
    i = body_pos;
    case (parse_phase)
      PH_BODY: begin
        if (hdr_cmd == CMD_CONNACK && i == 1) ack_byte = 32'(b);
        if (hdr_cmd >= CMD_ACK_FIRST && hdr_cmd <= CMD_ACK_LAST) begin
          if (i == 0) pkt_id = 32'({b, 8'h00});
          else if (i == 1) pkt_id = pkt_id | 32'(b);
        end
      end
      PH_PUB_TOPIC: begin
        if (i == 0) begin
          topic_len = 32'({b, 8'h00});
        end else if (i == 1) begin
          topic_len = topic_len | 32'(b);
          field_pos = 2 + topic_len;
          parse_phase = (hdr_qos != 0) ? PH_PUB_ID : PH_PUB_PROP;
        end
      end
      PH_PUB_ID: begin
        if (i == field_pos) begin
          pkt_id = 32'({b, 8'h00});
        end else if (i == field_pos + 1) begin
          pkt_id = pkt_id | 32'(b);
          field_pos += 2;
          parse_phase = PH_PUB_PROP;
        end
      end
      PH_PUB_PROP: begin
        if (i >= field_pos && prop_bytes < 4) begin
          prop_len = prop_len | (32'(b[6:0]) << (7 * prop_bytes));
          prop_bytes++;
          if (!b[7]) parse_phase = PH_PUB_TAIL;
        end
      end
      default: ;
    endcase
    body_pos = i + 1;
    if (body_pos >= rem_len) begin
      r = close_packet(1'b0);
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      $display("%0t %s mismatch: expected %0d, actual %0d", $time, name, want, got);
      errors++;
    end
  endfunction

  // per-transaction wait, with calm stretches of back-to-back traffic
  function automatic int draw_wait(inout bit calm);
    if ($urandom_range(0, 31) == 0) calm = !calm;
    if (calm || $urandom_range(0, 1) == 1) return 0;
    return $urandom_range(0, 11);
  endfunction

  // varint group k of value v spread over the given number of groups
  function automatic logic [7:0] len_group(input int v, input int k, input int groups);
    return {1'(k < groups - 1), 7'(v >> (7 * k))};
  endfunction

  // monitor: check results, then predict from accepted bytes
  always @(posedge clk) begin : watch
    res_t want;
    res_t hdr_res;
    in_taken <= in_valid && in_ready;
    out_taken <= out_valid && out_ready;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (expected_headers.size() == 0) begin
          $display("%0t unexpected result: expected none, actual command %0d status %0d",
                   $time, out_command, out_status);
          errors++;
        end else begin
          want = expected_headers.pop_front();
          check_field("status", 32'(want.status), 32'(out_status));
          check_field("command", 32'(want.command), 32'(out_command));
          check_field("qos_level", 32'(want.qos_level), 32'(out_qos_level));
          check_field("packet_length", 32'(want.packet_length), 32'(out_packet_length));
          check_field("remaining_length", 32'(want.remaining_length),
                      32'(out_remaining_length));
          check_field("packet_id", 32'(want.packet_id), 32'(out_packet_id));
          check_field("ack_code", 32'(want.ack_code), 32'(out_ack_code));
          check_field("topic_length", 32'(want.topic_length), 32'(out_topic_length));
          check_field("prop_offset", 32'(want.prop_offset), 32'(out_prop_offset));
          check_field("prop_length", 32'(want.prop_length), 32'(out_prop_length));
          check_field("payload_offset", 32'(want.payload_offset), 32'(out_payload_offset));
          check_field("payload_length", 32'(want.payload_length), 32'(out_payload_length));
          headers_seen++;
        end
      end
      if (in_valid && in_ready) begin
        if (parse_byte(in_rx_byte, hdr_res)) expected_headers.push_back(hdr_res);
      end
    end
  end

  // byte driver
  always @(negedge clk) begin : feed
    if (in_valid && !in_taken) begin
      // hold the offered byte until taken
    end else if (feed_gap > 0) begin
      feed_gap <= feed_gap - 1;
      in_valid <= 1'b0;
    end else if (tx_bytes.size() != 0) begin
      in_rx_byte <= tx_bytes.pop_front();
      in_valid <= 1'b1;
      feed_gap <= draw_wait(feed_calm);
    end else begin
      in_valid <= 1'b0;
    end
  end

  // result receiver, with one long hold-off to fill the block
  always @(negedge clk) begin : drain
    int w;
    bit h;
    w = drain_wait;
    if (out_taken) w = draw_wait(drain_calm);
    else if (w > 0) w--;
    h = hold_left > 0;
    if (!hold_done && headers_seen >= 10) begin
      hold_left <= 400;
      hold_done <= 1'b1;
      h = 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
    drain_wait <= w;
    out_ready <= rst_n && w == 0 && !h;
  end

  task automatic add_u16(input logic [15:0] v);
    pkt_body.push_back(v[15:8]);
    pkt_body.push_back(v[7:0]);
  endtask

  task automatic add_random(input int cnt);
    int k;
    for (k = 0; k < cnt; k++) pkt_body.push_back(8'($urandom));
  endtask

  // queue first byte, remaining length and body; groups 0 picks a random encoding
  task automatic send_packet(input logic [7:0] first, input int groups);
    int n, k;
    n = pkt_body.size();
    if (groups == 0) groups = ($urandom_range(0, 5) == 0) ? $urandom_range(2, 4) : 1;
    if (n >= 128 && groups < 2) groups = 2;
    tx_bytes.push_back(first);
    for (k = 0; k < groups; k++) tx_bytes.push_back(len_group(n, k, groups));
    foreach (pkt_body[j]) tx_bytes.push_back(pkt_body[j]);
    tx_count += 1 + groups + n;
    pkt_body.delete();
  endtask

  task automatic send_publish(input logic [1:0] qos, input int topic, input int prop,
                              input int pgroups, input int payload);
    int k;
    add_u16(16'(topic));
    add_random(topic);
    if (qos != 0) add_u16(16'($urandom_range(0, 65535)));
    for (k = 0; k < pgroups; k++) pkt_body.push_back(len_group(prop, k, pgroups));
    if (pgroups > 0) add_random(prop);
    add_random(payload);
    send_packet({CMD_PUBLISH, 1'($urandom), qos, 1'($urandom)}, 0);
  endtask

  // well-formed packet of a random type with random content
  task automatic send_random_packet();
    logic [3:0] flags;
    logic [3:0] cmd;
    int pgroups;
    flags = 4'($urandom);
    pgroups = ($urandom_range(0, 3) == 0) ? $urandom_range(2, 4) : 1;
    if (!mode_v5 && $urandom_range(0, 1) == 0) pgroups = 0;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: begin
        send_publish(2'($urandom), $urandom_range(0, 10), $urandom_range(0, 6), pgroups,
                     $urandom_range(0, 12));
      end
      4: begin
        add_random(2 + $urandom_range(0, 3));
        send_packet({CMD_CONNACK, flags}, 0);
      end
      5, 6, 7: begin
        add_random(2 + $urandom_range(0, 8));
        send_packet({4'($urandom_range(CMD_ACK_FIRST, CMD_ACK_LAST)), flags}, 0);
      end
      default: begin
        case ($urandom_range(0, 5))
          0:       cmd = CMD_RESERVED;
          1:       cmd = CMD_CONNECT;
          2:       cmd = CMD_PINGREQ;
          3:       cmd = CMD_PINGRESP;
          4:       cmd = CMD_DISCONNECT;
          default: cmd = CMD_AUTH;
        endcase
        add_random($urandom_range(0, 10));
        send_packet({cmd, flags}, 0);
      end
    endcase
  endtask

  // one malformed packet, then bytes that must be dropped
  task automatic break_stream();
    int k;
    case ($urandom_range(0, 5))
      0: begin
        // continuation bit still set on the fourth length byte
        tx_bytes.push_back(8'($urandom));
        for (k = 0; k < 4; k++) tx_bytes.push_back({1'b1, 7'($urandom)});
      end
      1: begin
        // ack type with a body shorter than two bytes
        add_random($urandom_range(0, 1));
        send_packet({($urandom_range(0, 1) == 1) ? CMD_CONNACK :
                     4'($urandom_range(CMD_ACK_FIRST, CMD_ACK_LAST)), 4'($urandom)}, 0);
      end
      2: begin
        // topic longer than the packet
        add_u16(16'd5);
        add_random(3);
        send_packet({CMD_PUBLISH, 1'($urandom), 2'($urandom), 1'($urandom)}, 0);
      end
      3: begin
        // packet id cut off
        add_u16(16'd2);
        add_random(3);
        send_packet({CMD_PUBLISH, 1'($urandom), 2'($urandom_range(1, 3)), 1'($urandom)}, 0);
      end
      4: begin
        // property varint that never ends
        add_u16(16'd0);
        for (k = $urandom_range(3, 6); k > 0; k--) pkt_body.push_back({1'b1, 7'($urandom)});
        send_packet({CMD_PUBLISH, 1'($urandom), 2'b00, 1'($urandom)}, 0);
      end
      default: begin
        // property section larger than the packet
        add_u16(16'd0);
        pkt_body.push_back(8'd20);
        add_random(3);
        send_packet({CMD_PUBLISH, 1'($urandom), 2'b00, 1'($urandom)}, 0);
      end
    endcase
    for (k = 0; k < 20; k++) tx_bytes.push_back(8'($urandom));
  endtask

  // wait until all bytes are in and all headers are out, then let the pipe drain
  task automatic settle();
    while (tx_bytes.size() != 0 || in_valid || expected_headers.size() != 0)
      @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_mode(input bit v5);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v5;
    mode_v5 = v5;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic random_traffic(input int nbytes);
    int stop_at;
    stop_at = tx_count + nbytes;
    while (tx_count < stop_at) send_random_packet();
  endtask

  initial begin : stimulus
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed, version 3 rules
    send_packet({CMD_PINGREQ, 4'h0}, 1);
    send_packet({CMD_CONNECT, 4'hf}, 4);
    pkt_body.push_back(8'h00);
    pkt_body.push_back(8'hff);
    send_packet({CMD_CONNACK, 4'h0}, 1);
    add_random(4);
    send_packet({CMD_CONNACK, 4'h0}, 2);
    add_u16(16'hffff);
    send_packet({CMD_PUBACK, 4'h0}, 1);
    add_u16(16'h0000);
    send_packet({CMD_ACK_LAST, 4'h0}, 1);
    add_random(7);
    send_packet({CMD_SUBSCRIBE, 4'h2}, 3);
    send_publish(2'd0, 0, 0, 0, 0);
    send_publish(2'd1, 3, 0, 0, 5);
    send_publish(2'd3, 1, 0, 0, 0);
    add_random(127);
    send_packet({CMD_AUTH, 4'h0}, 1);
    add_random(3);
    send_packet({CMD_RESERVED, 4'h0}, 1);
    send_packet({CMD_PINGRESP, 4'h0}, 2);
    random_traffic(70);

    // version 5 property parsing
    settle();
    set_mode(1'b1);
    send_publish(2'd0, 2, 0, 1, 4);
    send_publish(2'd1, 1, 3, 2, 2);
    send_publish(2'd2, 0, 5, 4, 0);
    send_publish(2'd0, 1, 0, 1, 1);
    send_publish(2'd1, 0, 127, 1, 0);
    random_traffic(70);

    settle();
    set_mode(1'b0);
    random_traffic(70);

    settle();
    set_mode(1'b1);
    random_traffic(70);
    break_stream();

    settle();
    if (errors == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

  initial begin : watchdog
    #1_000_000;
    $display("status: fail");
    $finish;
  end

endmodule
